@@ src/fmmt_pkg.sv @@
package fmmt_pkg;

  localparam int unsigned DefMaxRows  = 16;
  localparam int unsigned DefMaxInner = 64;
  localparam int unsigned RowW        = 5;
  localparam int unsigned InnerW      = 7;
  localparam logic [31:0] CanonNan    = 32'h7FC0_0000;

  typedef enum logic [0:0] {
    REQ_LOAD    = 1'b0,
    REQ_COMPUTE = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    REG_ROW_COUNT   = 1'b0,
    REG_INNER_COUNT = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [31:0] a_value;
    logic [31:0] b_value;
    logic [3:0]  column_index;
  } in_word_t;

  typedef struct packed {
    logic [31:0] c_value;
    logic [3:0]  row_index;
    logic        last;
  } out_word_t;

  // IEEE single multiply, round to nearest even, subnormals kept.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic signed [10:0] e;
    logic [49:0] w;
    int unsigned lz;
    int          sh;
    logic [23:0] m;
    logic        g, st, rnd;
    logic [24:0] mr;
    logic [31:0] r;
    s  = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    ma = {(ea != 8'd0), a[22:0]};
    mb = {(eb != 8'd0), b[22:0]};
    r  = 32'd0;
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
      r = CanonNan;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if ((ea == 8'hFF && b[30:0] == 0) || (eb == 8'hFF && a[30:0] == 0)) r = CanonNan;
      else r = {s, 8'hFF, 23'd0};
    end else if (a[30:0] == 0 || b[30:0] == 0) begin
      r = {s, 31'd0};
    end else begin
      p  = ma * mb;
      e  = 11'(signed'({3'd0, (ea == 0) ? 8'd1 : ea})) +
           11'(signed'({3'd0, (eb == 0) ? 8'd1 : eb})) - 11'sd126;
      // Normalize so the leading one sits at bit 47.
      lz = 0;
      for (int i = 47; i >= 0; i--) begin
        if (p[i] && lz == 0) lz = 48 - i;
      end
      lz = lz - 1;
      p  = p << lz;
      e  = e - 11'(lz);
      w  = {p, 2'b00};
      if (e < 1) begin
        sh = 1 - int'(e);
        if (sh > 49) sh = 49;
        st = 1'b0;
        for (int i = 0; i < 50; i++) if (i < sh && w[i]) st = 1'b1;
        w = w >> sh;
        w[0] = w[0] | st;
        e = 11'sd0;
      end
      m   = w[49:26];
      g   = w[25];
      st  = |w[24:0];
      rnd = g & (st | m[0]);
      mr  = {1'b0, m} + 25'(rnd);
      if (e == 0) begin
        r = {s, 7'd0, mr[23], mr[22:0]};
      end else begin
        if (mr[24]) begin
          mr = mr >> 1;
          e  = e + 11'sd1;
        end
        if (e >= 255) r = {s, 8'hFF, 23'd0};
        else r = {s, e[7:0], mr[22:0]};
      end
    end
    return r;
  endfunction

  // IEEE single add, round to nearest even, subnormals kept.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea, eb;
    logic [31:0] x, y;
    logic [26:0] mx, my;
    logic [27:0] sum;
    int          d, lz;
    logic        st, rnd, s;
    int          e;
    logic [23:0] m;
    logic [24:0] mr;
    logic [31:0] r;
    ea = a[30:23];
    eb = b[30:23];
    r  = 32'd0;
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
      r = CanonNan;
    end else if (ea == 8'hFF || eb == 8'hFF) begin
      if (ea == 8'hFF && eb == 8'hFF && a[31] != b[31]) r = CanonNan;
      else r = (ea == 8'hFF) ? a : b;
    end else begin
      if (a[30:0] >= b[30:0]) begin x = a; y = b; end
      else begin x = b; y = a; end
      mx = {(x[30:23] != 0), x[22:0], 3'b000};
      my = {(y[30:23] != 0), y[22:0], 3'b000};
      d  = int'((x[30:23] == 0) ? 8'd1 : x[30:23]) - int'((y[30:23] == 0) ? 8'd1 : y[30:23]);
      if (d > 27) d = 27;
      st = 1'b0;
      for (int i = 0; i < 27; i++) if (i < d && my[i]) st = 1'b1;
      my = my >> d;
      my[0] = my[0] | st;
      s = x[31];
      e = int'((x[30:23] == 0) ? 8'd1 : x[30:23]);
      if (x[31] == y[31]) sum = {1'b0, mx} + {1'b0, my};
      else sum = {1'b0, mx} - {1'b0, my};
      if (sum == 0) begin
        r = {a[31] & b[31], 31'd0};
      end else begin
        if (sum[27]) begin
          sum = {1'b0, sum[27:2], sum[1] | sum[0]};
          e = e + 1;
        end else begin
          lz = 0;
          for (int i = 26; i >= 0; i--) if (sum[i] && lz == 0) lz = 27 - i;
          lz = lz - 1;
          if (lz > e - 1) lz = e - 1;
          sum = sum << lz;
          e = e - lz;
        end
        m   = sum[26:3];
        rnd = sum[2] & ((|sum[1:0]) | m[0]);
        mr  = {1'b0, m} + 25'(rnd);
        if (mr[24]) begin
          mr = mr >> 1;
          e = e + 1;
        end
        if (e >= 255) r = {s, 8'hFF, 23'd0};
        else if (mr[23] == 1'b0) r = {s, 8'd0, mr[22:0]};
        else r = {s, 8'(e), mr[22:0]};
      end
    end
    return r;
  endfunction

endpackage

@@ src/fmmt_front.sv @@
// Front end: takes input words, writes load pairs into the stores and
// queues compute requests for the back end.
module fmmt_front #(
  parameter int unsigned MaxRows  = fmmt_pkg::DefMaxRows,
  parameter int unsigned MaxInner = fmmt_pkg::DefMaxInner,
  localparam int unsigned Depth   = MaxRows * MaxInner,
  localparam int unsigned AddrW   = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fmmt_pkg::in_word_t   in_word_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cfg_write_i,
  input  logic [AddrW:0]       total_i,
  output logic                 wr_en_o,
  output logic [AddrW-1:0]     wr_addr_o,
  output logic [31:0]          wr_a_o,
  output logic [31:0]          wr_b_o,
  output logic                 cmd_valid_o,
  output logic [3:0]           cmd_col_o,
  input  logic                 cmd_take_i,
  input  logic                 back_busy_i
);
  import fmmt_pkg::*;

  logic [AddrW:0] pos_q, pos_d, pos_use;
  logic [3:0]     col_q [2];
  logic [1:0]     cnt_q;
  logic           wp_q, rp_q;
  logic           accept, push;

  // A compute word waits for room in the queue. A load word waits until no
  // column is queued or in progress, so every column reads the stores as they
  // stood when it was requested.
  assign in_stall_o = in_valid_i &&
                      ((in_word_i.req_type == REQ_COMPUTE && cnt_q == 2'd2) ||
                       (in_word_i.req_type == REQ_LOAD && (cnt_q != 2'd0 || back_busy_i)));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && in_word_i.req_type == REQ_COMPUTE;

  // Load position wraps after the last element.
  always_comb begin
    pos_use = (pos_q >= total_i) ? '0 : pos_q;
    pos_d   = pos_use + 1'b1;
    if (pos_d >= total_i) pos_d = '0;
  end

  assign wr_en_o   = accept && in_word_i.req_type == REQ_LOAD;
  assign wr_addr_o = pos_use[AddrW-1:0];
  assign wr_a_o    = in_word_i.a_value;
  assign wr_b_o    = in_word_i.b_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cfg_write_i) begin
      pos_q <= '0;
    end else if (wr_en_o) begin
      pos_q <= pos_d;
    end
  end

  // Two-entry command queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_take_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) col_q[wp_q] <= in_word_i.column_index;
  end

  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_col_o   = col_q[rp_q];

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("command queue overflow");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_take_i |-> cmd_valid_o)
    else $error("take from empty queue");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en_o |-> pos_use < total_i)
    else $error("load position out of range");
endmodule

@@ src/fmmt_back.sv @@
// Back end: walks one column, one product per cycle, four lane sums,
// then the lane reduction and the output register.
module fmmt_back #(
  parameter int unsigned MaxRows  = fmmt_pkg::DefMaxRows,
  parameter int unsigned MaxInner = fmmt_pkg::DefMaxInner,
  localparam int unsigned Depth   = MaxRows * MaxInner,
  localparam int unsigned AddrW   = $clog2(Depth),
  localparam int unsigned KW      = $clog2(MaxInner + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [fmmt_pkg::RowW-1:0] rows_i,
  input  logic [KW-1:0]        inner_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic [31:0]          wr_a_i,
  input  logic [31:0]          wr_b_i,
  input  logic                 cmd_valid_i,
  input  logic [3:0]           cmd_col_i,
  output logic                 cmd_take_o,
  output logic                 busy_o,
  output fmmt_pkg::out_word_t  out_word_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);
  import fmmt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_DRN  = 5'b00100,
    ST_RED  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e        st_q;
  logic [31:0]   a_mem [Depth];
  logic [31:0]   b_mem [Depth];
  logic [31:0]   ra_q, rb_q, prod_q;
  logic [31:0]   lane_q [4];
  logic [3:0]    col_q, row_q;
  logic [KW-1:0] k_q;
  logic [1:0]    rk_q, pk_q;
  logic          rv_q, pv_q;
  logic [1:0]    red_q;
  logic [AddrW+6:0] pa, pb;
  logic          issue;

  assign issue = st_q == ST_RUN;
  assign pa = (AddrW+7)'(row_q) + (AddrW+7)'(rows_i) * (AddrW+7)'(k_q);
  assign pb = (AddrW+7)'(col_q) + (AddrW+7)'(rows_i) * (AddrW+7)'(k_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      a_mem[wr_addr_i] <= wr_a_i;
      b_mem[wr_addr_i] <= wr_b_i;
    end
    ra_q   <= a_mem[pa[AddrW-1:0]];
    rb_q   <= b_mem[pb[AddrW-1:0]];
    prod_q <= fp_mul(ra_q, rb_q);
  end

  assign cmd_take_o = st_q == ST_IDLE && cmd_valid_i;
  assign busy_o     = st_q != ST_IDLE;

  // Sequencer: read, multiply, accumulate pipeline, then reduce and emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      rv_q  <= 1'b0;
      pv_q  <= 1'b0;
      out_valid_o <= 1'b0;
      k_q <= '0; row_q <= '0; col_q <= '0; rk_q <= '0; pk_q <= '0; red_q <= '0;
    end else begin
      rv_q <= issue;
      rk_q <= k_q[1:0];
      pv_q <= rv_q;
      pk_q <= rk_q;
      if (pv_q) lane_q[pk_q] <= fp_add(lane_q[pk_q], prod_q);
      if (out_valid_o && !out_stall_i && st_q != ST_OUT) out_valid_o <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if ({1'b0, cmd_col_i} < rows_i) begin
              col_q <= cmd_col_i;
              row_q <= '0;
              k_q <= '0;
              for (int l = 0; l < 4; l++) lane_q[l] <= '0;
              st_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (k_q == inner_i - 1'b1) st_q <= ST_DRN;
          k_q <= k_q + 1'b1;
        end
        ST_DRN: begin
          if (!rv_q && !pv_q) begin
            red_q <= 2'd1;
            st_q  <= ST_RED;
          end
        end
        ST_RED: begin
          lane_q[0] <= fp_add(lane_q[0], lane_q[red_q]);
          red_q <= red_q + 2'd1;
          if (red_q == 2'd3) st_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o <= 1'b1;
            out_word_o.c_value   <= lane_q[0];
            out_word_o.row_index <= row_q;
            out_word_o.last      <= {1'b0, row_q} == rows_i - 1'b1;
            for (int l = 0; l < 4; l++) lane_q[l] <= '0;
            k_q <= '0;
            if ({1'b0, row_q} == rows_i - 1'b1) st_q <= ST_IDLE;
            else begin
              row_q <= row_q + 1'b1;
              st_q  <= ST_RUN;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result changed");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_RED |-> !pv_q && !rv_q)
    else $error("reduction during accumulation");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> st_q == ST_IDLE)
    else $error("command taken while busy");
endmodule

@@ src/float_matrix_times_transpose_top.sv @@
// Single precision C = A * transpose(B) engine.
// Input channel (in_word_i/in_valid_i/in_stall_o): a load word writes one A
// and one B element at the running column-major position, one per cycle
// while not stalled. A compute word names column j; it is queued (two deep)
// and the back end emits row_count result words C[0..rows-1][j] with last on
// the final one. Each entry issues inner_count products, one per cycle,
// drains the read, multiply and lane add registers, then runs three lane
// reductions and the output step. A column index not below row_count
// yields no words. Load words stall while a column is queued or
// being computed. Configuration (cfg_valid_i/cfg_ready_o, cfg_index_i,
// cfg_data_i): index 0 is row_count, index 1 inner_count; any write returns
// the load position to zero. Write only while idle.
// Reset sets row_count 16, inner_count 64 and load position 0; stores are
// undefined until loaded. When the receiver stalls, the output word holds
// and the sequencer waits.
module float_matrix_times_transpose_top #(
  parameter int unsigned MaxRows  = fmmt_pkg::DefMaxRows,
  parameter int unsigned MaxInner = fmmt_pkg::DefMaxInner
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmmt_pkg::in_word_t  in_word_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output fmmt_pkg::out_word_t out_word_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import fmmt_pkg::*;

  localparam int unsigned Depth = MaxRows * MaxInner;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned KW    = $clog2(MaxInner + 1);

  logic [RowW-1:0]   rows_q, rows_eff;
  logic [InnerW-1:0] inner_q;
  logic [KW-1:0]     inner_eff;
  logic [AddrW:0]    total;
  logic              cfg_we, wr_en, cmd_valid, cmd_take, back_busy;
  logic [AddrW-1:0]  wr_addr;
  logic [31:0]       wr_a, wr_b;
  logic [3:0]        cmd_col;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= RowW'(16);
      inner_q <= InnerW'(64);
    end else if (cfg_we) begin
      if (cfg_index_i == REG_ROW_COUNT) rows_q <= cfg_data_i[RowW-1:0];
      else inner_q <= cfg_data_i[InnerW-1:0];
    end
  end

  // Clamp the registers to the supported range.
  always_comb begin
    rows_eff = rows_q;
    if (rows_q == 0) rows_eff = RowW'(1);
    else if (32'(rows_q) > MaxRows) rows_eff = RowW'(MaxRows);
    inner_eff = KW'(inner_q);
    if (inner_q == 0) inner_eff = KW'(1);
    else if (32'(inner_q) > MaxInner) inner_eff = KW'(MaxInner);
    total = (AddrW+1)'(32'(rows_eff) * 32'(inner_eff));
  end

  fmmt_front #(.MaxRows(MaxRows), .MaxInner(MaxInner)) u_front (
    .clk_i, .rst_ni, .in_word_i, .in_valid_i, .in_stall_o,
    .cfg_write_i(cfg_we), .total_i(total),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_a_o(wr_a), .wr_b_o(wr_b),
    .cmd_valid_o(cmd_valid), .cmd_col_o(cmd_col), .cmd_take_i(cmd_take),
    .back_busy_i(back_busy)
  );

  fmmt_back #(.MaxRows(MaxRows), .MaxInner(MaxInner)) u_back (
    .clk_i, .rst_ni, .rows_i(rows_eff), .inner_i(inner_eff),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_a_i(wr_a), .wr_b_i(wr_b),
    .cmd_valid_i(cmd_valid), .cmd_col_i(cmd_col), .cmd_take_o(cmd_take),
    .busy_o(back_busy),
    .out_word_o, .out_valid_o, .out_stall_i
  );
endmodule
